FILE: design/cmcs_pkg.sv
// Shared constants, codes and types of the context model counter store.
package cmcs_pkg;

    localparam int NUM_CONTEXTS = 65536;
    localparam int MAX_SYMBOLS  = 4;
    localparam int COUNTER_BITS = 16;

    localparam int ADDR_W       = $clog2(NUM_CONTEXTS);
    localparam int CTX_W        = 16;
    localparam int SYM_W        = 2;
    localparam int FREQ_W       = 32;
    localparam int TOTAL_W      = 34;
    localparam int FREQ_LANES   = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [31:0] NUM_CTX_L = 32'(NUM_CONTEXTS);
    localparam logic [31:0] CTX_RECIP = 32'((64'd1 << 32) / NUM_CONTEXTS);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] CFG_COUNT_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_FREQ_OFFSET  = 2'd2;
    localparam logic [1:0] CFG_FREQ_SCALE   = 2'd3;

    typedef logic [COUNTER_BITS-1:0] t_count;
    typedef t_count [MAX_SYMBOLS-1:0] t_entry;

    typedef struct packed {
        logic [1:0]       action;
        logic [CTX_W-1:0] context_index;
        logic [SYM_W-1:0] symbol;
    } t_in_data;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq_a;
        logic [FREQ_W-1:0]  freq_b;
        logic [FREQ_W-1:0]  freq_c;
        logic [FREQ_W-1:0]  freq_d;
        logic [TOTAL_W-1:0] freq_total;
    } t_out_data;

    typedef struct packed {
        logic [FREQ_LANES-1:0] used;
        logic [15:0]           offset;
        logic [15:0]           scale;
    } t_freq_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_freq_stat;

endpackage

FILE: design/cmcs_freq.sv
// Three-stage pipeline that turns one entry of counters into frequency estimates and their total.
module cmcs_freq
    import cmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_entry     i_entry,
    input  t_freq_cfg  i_cfg,
    output t_freq_stat o_stat,
    output t_out_data  o_result
);

    logic [COUNTER_BITS-1:0] lane_count [FREQ_LANES];
    logic [FREQ_W-1:0]       r_prod     [FREQ_LANES];
    logic [FREQ_W-1:0]       r_freq     [FREQ_LANES];
    logic [TOTAL_W-1:0]      total_sum;
    logic [2:0]              r_valid;
    t_out_data               r_result;

    for (genvar k = 0; k < FREQ_LANES; k++) begin : g_lane
        if (k < MAX_SYMBOLS) begin : g_used
            assign lane_count[k] = i_entry[k];
        end else begin : g_unused
            assign lane_count[k] = '0;
        end
    end

    always_comb begin
        total_sum = '0;
        for (int k = 0; k < FREQ_LANES; k++) begin
            total_sum = total_sum + TOTAL_W'(r_freq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FREQ_LANES; k++) begin
            if (i_start) begin
                r_prod[k] <= FREQ_W'(i_cfg.scale) * FREQ_W'(lane_count[k]);
            end
            if (r_valid[0]) begin
                r_freq[k] <= i_cfg.used[k] ? FREQ_W'(i_cfg.offset) + r_prod[k] : '0;
            end
        end
        if (r_valid[1]) begin
            r_result.freq_a     <= r_freq[0];
            r_result.freq_b     <= r_freq[1];
            r_result.freq_c     <= r_freq[2];
            r_result.freq_d     <= r_freq[3];
            r_result.freq_total <= total_sum;
        end
    end

    assign o_stat.busy = |r_valid;
    assign o_stat.done = r_valid[2];
    assign o_result    = r_result;

endmodule

FILE: design/context_model_counter_store.sv
// Top level of the context model counter store: entry memory, item sequencer and config registers.
//
// Each context owns one memory entry of MAX_SYMBOLS counters. An item is taken in S_IDLE and
// holds the sequencer until done: the context index is reduced modulo NUM_CONTEXTS on acceptance
// and in S_MAP, the entry is read in S_READ and written back or handed to the frequency pipeline
// in S_MODIFY. A query result passes through the frequency pipeline into the output register; a
// query waits in S_MODIFY while an earlier result is still in the pipeline or not yet taken from
// the output register. The single-port read-modify-write of the entry memory sets the rate. A
// clear item, and reset, start a sweep that writes one entry a cycle over all NUM_CONTEXTS
// entries, during which no item is taken; config writes are always taken.
module context_model_counter_store
    import cmcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_data              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_data             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_READ,
        S_MODIFY
    } t_state;

    t_state r_state;

    logic [2:0]  r_symbol_count;
    logic [15:0] r_count_limit;
    logic [15:0] r_freq_offset;
    logic [15:0] r_freq_scale;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [1:0]        r_action;
    logic [SYM_W-1:0]  r_symbol;
    logic [CTX_W-1:0]  r_ctx;
    logic [CTX_W-1:0]  r_q;
    t_entry            r_rd_data;
    logic              r_out_valid;
    t_out_data         r_out_data;

    t_entry            mem [NUM_CONTEXTS];

    logic              in_accept;
    logic              sym_ok;
    logic [47:0]       q_prod;
    logic [31:0]       qn_prod;
    logic [CTX_W:0]    diff;
    logic [31:0]       rem;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    t_entry            inc_entry;
    t_entry            upd_entry;
    t_count            hit_val;
    logic              halve;
    logic              launch;
    t_freq_cfg         freq_cfg;
    t_freq_stat        freq_stat;
    t_out_data         freq_result;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        for (int k = 0; k < FREQ_LANES; k++) begin
            freq_cfg.used[k] = (k < MAX_SYMBOLS) && (3'(k) < r_symbol_count);
        end
        freq_cfg.offset = r_freq_offset;
        freq_cfg.scale  = r_freq_scale;
    end

    assign sym_ok = (3'(i_in_data.symbol) < r_symbol_count) &&
                    (32'(i_in_data.symbol) < MAX_SYMBOLS);

    assign q_prod  = 48'(i_in_data.context_index) * 48'(CTX_RECIP);
    assign qn_prod = 32'(r_q) * NUM_CTX_L;
    assign diff    = {1'b0, r_ctx} - (CTX_W+1)'(qn_prod);
    assign rem     = (32'(diff) >= NUM_CTX_L) ? 32'(diff) - NUM_CTX_L : 32'(diff);

    always_comb begin
        hit_val = '0;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            if (r_symbol == SYM_W'(k)) begin
                inc_entry[k] = (r_rd_data[k] == CNT_MAX) ? r_rd_data[k]
                                                         : r_rd_data[k] + 1'b1;
                hit_val      = inc_entry[k];
            end else begin
                inc_entry[k] = r_rd_data[k];
            end
        end
        halve = (r_count_limit != '0) && (16'(hit_val) == r_count_limit);
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            upd_entry[k] = (halve && freq_cfg.used[k]) ? (inc_entry[k] >> 1) : inc_entry[k];
        end
    end

    assign launch  = (r_state == S_MODIFY) && (r_action == ACT_QUERY) &&
                     !r_out_valid && !freq_stat.busy;
    assign rd_en   = (r_state == S_READ);
    assign wr_en   = (r_state == S_CLEAR) ||
                     ((r_state == S_MODIFY) && (r_action == ACT_UPDATE));
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign wr_data = (r_state == S_CLEAR) ? '0 : upd_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= 3'd4;
            r_count_limit  <= '0;
            r_freq_offset  <= 16'd1;
            r_freq_scale   <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[2:0];
                CFG_COUNT_LIMIT:  r_count_limit  <= i_cfg_data;
                CFG_FREQ_OFFSET:  r_freq_offset  <= i_cfg_data;
                CFG_FREQ_SCALE:   r_freq_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (freq_stat.done) begin
                r_out_valid <= 1'b1;
                r_out_data  <= freq_result;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(NUM_CONTEXTS - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_action <= i_in_data.action;
                        r_symbol <= i_in_data.symbol;
                        r_ctx    <= i_in_data.context_index;
                        r_q      <= q_prod[47:32];
                        if (i_in_data.action == ACT_CLEAR) begin
                            r_state <= S_CLEAR;
                        end else if ((i_in_data.action == ACT_UPDATE && sym_ok) ||
                                     i_in_data.action == ACT_QUERY) begin
                            r_state <= S_MAP;
                        end
                    end
                end
                S_MAP: begin
                    r_addr  <= rem[ADDR_W-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_MODIFY;
                end
                S_MODIFY: begin
                    if (r_action != ACT_QUERY || launch) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    cmcs_freq u_freq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (launch),
        .i_entry  (r_rd_data),
        .i_cfg    (freq_cfg),
        .o_stat   (freq_stat),
        .o_result (freq_result)
    );

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        freq_stat.done |-> !r_out_valid)
        else $error("Frequency result arrived while the output register was full.");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("A stalled result beat was dropped or changed.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < NUM_CTX_L))
        else $error("Entry write address is beyond the number of contexts.");

endmodule
